>>> hdl/gfd_pkg.sv
// ----------------------------------------------------------------------------
// gfd_pkg
// Shared constants and types for the sync-header frame deframer with
// two 8-bit running checksums.
// ----------------------------------------------------------------------------
package gfd_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 128;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;

  typedef enum logic [6:0] {
    PH_HUNT   = 7'b000_0001,
    PH_SYNC2  = 7'b000_0010,
    PH_ID     = 7'b000_0100,
    PH_LEN    = 7'b000_1000,
    PH_PAY    = 7'b001_0000,
    PH_SUM_A  = 7'b010_0000,
    PH_SUM_B  = 7'b100_0000
  } phase_t;

  typedef enum logic [2:0] {
    EV_PAYLOAD    = 3'd0,
    EV_GOOD       = 3'd1,
    EV_FIRST_BAD  = 3'd2,
    EV_SECOND_BAD = 3'd3,
    EV_OVERSIZE   = 3'd4
  } event_kind_t;

endpackage

>>> hdl/gfd_if.sv
// ----------------------------------------------------------------------------
// gfd_if
// Valid/ready channels of the frame deframer: received bytes in, events out.
// ----------------------------------------------------------------------------
interface gfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  message_id;
  logic [7:0]  payload_byte;
  logic [7:0]  byte_index;
  logic [7:0]  frame_length;
  logic [31:0] packet_count;
  logic [31:0] error_count;

  modport source (output valid, output event_kind, output message_id, output payload_byte,
                  output byte_index, output frame_length, output packet_count,
                  output error_count, input ready);
  modport sink   (input valid, input event_kind, input message_id, input payload_byte,
                  input byte_index, input frame_length, input packet_count,
                  input error_count, output ready);
endinterface

>>> hdl/gps_frame_deframer_fletcher_core.sv
// ----------------------------------------------------------------------------
// gps_frame_deframer_fletcher_core
// Hunts for 0x55 0xAA, reads id and length, forwards payload bytes and
// reports the frame verdict from two 8-bit running checksums.
// ----------------------------------------------------------------------------
//  channel   direction  transfer carries
//  in_if     sink       one received byte
//  out_if    source     payload byte event or frame verdict, with counters
//
//  One byte per cycle while out_if.ready stays high; a byte's result goes from
//  the input register into the result register and is on out_if from then on.
//  The input register doubles as a skid stage, so one more byte is taken while
//  a result waits on out_if.ready; with both registers full in_if.ready drops.
//  rst_n is synchronous, active low; it clears phase, sums and counters.
//  Bytes that cause no event leave no result.
// ----------------------------------------------------------------------------
module gps_frame_deframer_fletcher_core #(
  parameter int unsigned MAX_PAYLOAD = gfd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gfd_in_if.sink    in_if,
  gfd_out_if.source out_if
);
  import gfd_pkg::*;

  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  logic        s1_valid_r;
  logic [7:0]  byte_r;
  logic        adv;
  logic        step;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  rcnt_r, rcnt_nxt;
  logic        skip_r, skip_nxt;
  logic [31:0] good_r, good_nxt;
  logic [31:0] bad_r, bad_nxt;

  logic        emit;
  event_kind_t kind;
  logic [7:0]  pay;
  logic [7:0]  idx;
  logic [7:0]  acc_a;
  logic [7:0]  acc_b;

  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  logic [7:0]  out_id_r;
  logic [7:0]  out_pay_r;
  logic [7:0]  out_idx_r;
  logic [7:0]  out_len_r;
  logic [31:0] out_good_r;
  logic [31:0] out_bad_r;

  assign adv         = !out_valid_r || out_if.ready;
  assign step        = s1_valid_r && adv;
  assign in_if.ready = !s1_valid_r || adv;

  assign acc_a = sum_a_r + byte_r;
  assign acc_b = sum_b_r + acc_a;

  always_comb begin
    phase_nxt = phase_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    rcnt_nxt  = rcnt_r;
    skip_nxt  = skip_r;
    good_nxt  = good_r;
    bad_nxt   = bad_r;
    emit      = 1'b0;
    kind      = EV_PAYLOAD;
    pay       = 8'd0;
    idx       = 8'd0;
    unique case (phase_r)
      PH_HUNT: begin
        if (byte_r == SYNC_FIRST) begin
          skip_nxt  = 1'b0;
          phase_nxt = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        phase_nxt = (byte_r == SYNC_SECOND) ? PH_ID : PH_HUNT;
      end
      PH_ID: begin
        sum_a_nxt = byte_r;
        sum_b_nxt = byte_r;
        id_nxt    = byte_r;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        sum_a_nxt = acc_a;
        sum_b_nxt = acc_b;
        len_nxt   = byte_r;
        if (byte_r > MAX_LEN) begin
          bad_nxt   = bad_r + 32'd1;
          phase_nxt = PH_HUNT;
          emit      = 1'b1;
          kind      = EV_OVERSIZE;
        end else begin
          rcnt_nxt  = 8'd0;
          phase_nxt = (byte_r == 8'd0) ? PH_SUM_B : PH_PAY;
        end
      end
      PH_PAY: begin
        sum_a_nxt = acc_a;
        sum_b_nxt = acc_b;
        rcnt_nxt  = rcnt_r + 8'd1;
        if (rcnt_nxt >= len_r) begin
          phase_nxt = PH_SUM_A;
        end
        emit = 1'b1;
        kind = EV_PAYLOAD;
        pay  = byte_r;
        idx  = rcnt_r;
      end
      PH_SUM_A: begin
        phase_nxt = PH_SUM_B;
        if (sum_a_r != byte_r) begin
          skip_nxt = 1'b1;
          bad_nxt  = bad_r + 32'd1;
        end
      end
      PH_SUM_B: begin
        phase_nxt = PH_HUNT;
        emit      = 1'b1;
        if (sum_b_r != byte_r) begin
          bad_nxt = bad_r + 32'd1;
          kind    = EV_SECOND_BAD;
        end else begin
          good_nxt = good_r + 32'd1;
          kind     = skip_r ? EV_FIRST_BAD : EV_GOOD;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  // input register, also the skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
    if (in_if.ready) begin
      byte_r <= in_if.rx_byte;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sum_a_r <= 8'd0;
      sum_b_r <= 8'd0;
      id_r    <= 8'd0;
      len_r   <= 8'd0;
      rcnt_r  <= 8'd0;
      skip_r  <= 1'b0;
      good_r  <= 32'd0;
      bad_r   <= 32'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      rcnt_r  <= rcnt_nxt;
      skip_r  <= skip_nxt;
      good_r  <= good_nxt;
      bad_r   <= bad_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= step && emit;
    end
    if (step && emit) begin
      out_kind_r <= kind;
      out_id_r   <= id_nxt;
      out_pay_r  <= pay;
      out_idx_r  <= idx;
      out_len_r  <= len_nxt;
      out_good_r <= good_nxt;
      out_bad_r  <= bad_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.event_kind   = out_kind_r;
  assign out_if.message_id   = out_id_r;
  assign out_if.payload_byte = out_pay_r;
  assign out_if.byte_index   = out_idx_r;
  assign out_if.frame_length = out_len_r;
  assign out_if.packet_count = out_good_r;
  assign out_if.error_count  = out_bad_r;

endmodule
